/* src/asq_pkg.sv */
// asq_pkg: shared widths, register indexes, reset values and types for the
// adaptive subband quantizer. No dependencies.
`timescale 1ns / 1ps

package asq_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int CODE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_REGS   = 7;

   // divider: magnitude of the difference plus half a step, over the step size
   localparam int QUOT_W     = 17;
   localparam int DIVISOR_W  = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_QUANT_BITS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PREDICTOR_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_MAX       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_MIN       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_ALPHA    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_FLOOR    = 3'd6;

   // reset values of the registers
   localparam logic [3:0]         RST_QUANT_BITS     = 4'd4;
   localparam logic [15:0]        RST_STEP_GAIN      = 16'd1024;
   localparam logic [5:0]         RST_PREDICTOR_GAIN = 6'd0;
   localparam logic [6:0]         RST_CODE_MAX       = 7'd7;
   localparam logic signed [7:0]  RST_CODE_MIN       = -8'sd8;
   localparam logic [10:0]        RST_POWER_ALPHA    = 11'd960;
   localparam logic [14:0]        RST_POWER_FLOOR    = 15'd1;

   localparam logic [10:0]        ALPHA_ONE          = 11'd1024;
   localparam logic [15:0]        SAT_POS            = 16'd32767;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [CODE_W-1:0]   code_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* src/asq_req_if.sv */
// asq_req_if: sample channel, valid/ready handshake with one sample per item.
// Depends on asq_pkg.
`timescale 1ns / 1ps

interface asq_req_if import asq_pkg::*;;
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* src/asq_rsp_if.sv */
// asq_rsp_if: code channel, valid/ready handshake with one code per item.
// Depends on asq_pkg.
`timescale 1ns / 1ps

interface asq_rsp_if import asq_pkg::*;;
   logic     valid;
   logic     ready;
   code_type code;

   modport source (output valid, output code, input ready);
   modport sink   (input valid, input code, output ready);
endinterface

/* src/asq_csr_if.sv */
// asq_csr_if: register write channel carrying a register index and write data.
// Depends on asq_pkg.
`timescale 1ns / 1ps

interface asq_csr_if import asq_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* src/adaptive_subband_quantizer_core.sv */
// adaptive_subband_quantizer_core: adaptive quantizer with power, step and
// prediction tracking. Depends on asq_pkg, the channel interfaces and asq_div.
//
//   channel  dir  payload                     handshake
//   req_bus  in   sample  (16b signed)        valid/ready
//   rsp_bus  out  code    (8b signed)         valid/ready
//   csr_bus  in   index (3b), wdata (16b)     valid/ready, ready always high
//
// an item runs from accept through the bit-serial divider (17 quotient bits, then
// its done flag) and five passes through one shared 18x17 multiplier, with the
// power floor among them, then state update and output load.
// reset is synchronous; any register write reinitializes the adaptive state.
// a finished code waits in the output register while the next sample is taken;
// only the output load stalls, while that register is still full.
`timescale 1ns / 1ps

module adaptive_subband_quantizer_core import asq_pkg::*; (
   input logic         clock,
   input logic         reset,
   asq_req_if.sink     req_bus,
   asq_rsp_if.source   rsp_bus,
   asq_csr_if.sink     csr_bus
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_MDQ  = 4'd2;
   localparam logic [3:0] S_MPW0 = 4'd3;
   localparam logic [3:0] S_MPW1 = 4'd4;
   localparam logic [3:0] S_PW   = 4'd5;
   localparam logic [3:0] S_MST  = 4'd6;
   localparam logic [3:0] S_MPR  = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   function automatic logic [3:0] eff_qbits(input logic [3:0] q);
      logic [3:0] r;
      if (q == 4'd0) r = 4'd1;
      else if (q > 4'd8) r = 4'd8;
      else r = q;
      return r;
   endfunction

   function automatic logic [15:0] init_step(input logic [3:0] q);
      logic [3:0] sh;
      sh = 4'(5'd16 - {1'b0, eff_qbits(q)});
      return 16'd1 << sh;
   endfunction

   // configuration
   logic [3:0]        qbits_ff, qbits_in;
   logic [15:0]       sgain_ff, sgain_in;
   logic [5:0]        pgain_ff, pgain_in;
   logic [6:0]        cmax_ff, cmax_in;
   logic signed [7:0] cmin_ff, cmin_in;
   logic [10:0]       alpha_ff, alpha_in;
   logic [14:0]       floor_ff, floor_in;

   // adaptive state
   logic signed [15:0] pred_ff, pred_in;
   logic [15:0]        step_ff, step_in;
   logic [15:0]        power_ff, power_in;

   // per-item working registers
   logic [3:0]          state_ff, state_in;
   logic                neg_ff, neg_in;
   code_type            code_ff, code_in;
   logic signed [15:0]  dq_ff, dq_in;
   logic [15:0]         mag_ff, mag_in;
   logic [25:0]         acc_ff, acc_in;
   logic [16:0]         pw_ff, pw_in;
   logic [15:0]         st_ff, st_in;
   logic signed [34:0]  prod_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   code_type            rsp_code_ff, rsp_code_in;

   // shared multiplier
   logic signed [17:0]  mul_a;
   logic signed [16:0]  mul_b;
   logic signed [34:0]  mul_p;

   // divider hookup
   logic                div_start;
   logic [QUOT_W-1:0]   div_num;
   logic [QUOT_W-1:0]   div_quo;
   div_status_type      div_status;

   logic                req_fire, rsp_fire, csr_fire;
   logic [3:0]          effq;
   logic [10:0]         alpha_eff;
   logic signed [17:0]  diff;
   logic [16:0]         diff_mag;
   logic signed [17:0]  qval;
   logic signed [17:0]  cval;
   logic [26:0]         pw_sum;
   logic [16:0]         pw_raw;
   logic [3:0]          st_shift;
   logic [32:0]         st_round;
   logic [32:0]         st_raw;
   logic signed [34:0]  pr_raw;
   logic signed [17:0]  pred_dq;
   logic [16:0]         dq_abs;

   assign req_fire = req_bus.valid & req_bus.ready;
   assign rsp_fire = rsp_bus.valid & rsp_bus.ready;
   assign csr_fire = csr_bus.valid & csr_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.code  = rsp_code_ff;

   assign effq      = eff_qbits(qbits_ff);
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   // difference and rounded numerator for the divider
   assign diff      = 18'(req_bus.sample) - 18'(pred_ff);
   assign diff_mag  = diff[17] ? 17'(-diff) : 17'(diff);
   assign div_num   = diff_mag + 17'(step_ff >> 1);
   assign div_start = req_fire;

   asq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (step_ff),
      .quotient (div_quo),
      .status   (div_status)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         S_MDQ: begin
            mul_a = 18'(code_ff);
            mul_b = signed'({1'b0, step_ff});
         end
         S_MPW0: begin
            mul_a = signed'({7'd0, alpha_eff});
            mul_b = signed'({1'b0, power_ff});
         end
         S_MPW1: begin
            mul_a = signed'({7'd0, 11'(ALPHA_ONE - alpha_eff)});
            mul_b = signed'({1'b0, mag_ff});
         end
         S_MST: begin
            mul_a = signed'({2'd0, sgain_ff});
            mul_b = signed'(pw_ff);
         end
         S_MPR: begin
            mul_a = pred_dq;
            mul_b = signed'({11'd0, pgain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign pred_dq = 18'(pred_ff) + 18'(dq_ff);

   // code from quotient, clipped: upper limit first, then lower
   assign qval = signed'({1'b0, div_quo});
   assign cval = neg_ff ? -qval : qval;

   // leaky power average with rounding, floored
   assign pw_sum = 27'(acc_ff) + 27'(prod_ff[25:0]) + 27'd512;
   assign pw_raw = pw_sum[26:10];

   // step size: gain times power, rounding shift by code width plus four
   assign st_shift = effq + 4'd4;
   assign st_round = prod_ff[32:0] + (33'd1 << (st_shift - 4'd1));
   assign st_raw   = st_round >> st_shift;

   // prediction: rounding shift by five
   assign pr_raw = (prod_ff + 35'sd16) >>> 5;

   always_comb begin
      qbits_in     = qbits_ff;
      sgain_in     = sgain_ff;
      pgain_in     = pgain_ff;
      cmax_in      = cmax_ff;
      cmin_in      = cmin_ff;
      alpha_in     = alpha_ff;
      floor_in     = floor_ff;
      pred_in      = pred_ff;
      step_in      = step_ff;
      power_in     = power_ff;
      state_in     = state_ff;
      neg_in       = neg_ff;
      code_in      = code_ff;
      dq_in        = dq_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      pw_in        = pw_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      dq_abs       = '0;

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               neg_in   = diff[17];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               if (cval > 18'(signed'({1'b0, cmax_ff}))) begin
                  code_in = signed'({1'b0, cmax_ff});
               end else if (cval < 18'(cmin_ff)) begin
                  code_in = cmin_ff;
               end else begin
                  code_in = cval[7:0];
               end
               state_in = S_MDQ;
            end
         end
         S_MDQ: begin
            state_in = S_MPW0;
         end
         S_MPW0: begin
            // dequantized difference, saturated
            if (prod_ff > 35'sd32767) begin
               dq_in = 16'sd32767;
            end else if (prod_ff < -35'sd32768) begin
               dq_in = -16'sd32768;
            end else begin
               dq_in = prod_ff[15:0];
            end
            dq_abs   = dq_in[15] ? 17'(-18'(dq_in)) : 17'(dq_in);
            mag_in   = dq_abs[15:0];
            state_in = S_MPW1;
         end
         S_MPW1: begin
            acc_in   = prod_ff[25:0];
            state_in = S_PW;
         end
         S_PW: begin
            pw_in    = (pw_raw < 17'(floor_ff)) ? 17'(floor_ff) : pw_raw;
            state_in = S_MST;
         end
         S_MST: begin
            state_in = S_MPR;
         end
         S_MPR: begin
            if (st_raw == '0) begin
               st_in = 16'd1;
            end else if (st_raw > 33'(SAT_POS)) begin
               st_in = SAT_POS;
            end else begin
               st_in = st_raw[15:0];
            end
            state_in = S_UPD;
         end
         S_UPD: begin
            if (pr_raw > 35'sd32767) begin
               pred_in = 16'sd32767;
            end else if (pr_raw < -35'sd32768) begin
               pred_in = -16'sd32768;
            end else begin
               pred_in = pr_raw[15:0];
            end
            step_in  = st_ff;
            power_in = (pw_ff > 17'(SAT_POS)) ? SAT_POS : pw_ff[15:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a write with a valid index restarts the adaptive state
      if (csr_fire && (csr_bus.index < CSR_IDX_W'(NUM_REGS))) begin
         case (csr_bus.index)
            REG_QUANT_BITS:     qbits_in = csr_bus.wdata[3:0];
            REG_STEP_GAIN:      sgain_in = csr_bus.wdata[15:0];
            REG_PREDICTOR_GAIN: pgain_in = csr_bus.wdata[5:0];
            REG_CODE_MAX:       cmax_in  = csr_bus.wdata[6:0];
            REG_CODE_MIN:       cmin_in  = signed'(csr_bus.wdata[7:0]);
            REG_POWER_ALPHA:    alpha_in = csr_bus.wdata[10:0];
            REG_POWER_FLOOR:    floor_in = csr_bus.wdata[14:0];
            default:            qbits_in = qbits_ff;
         endcase
         pred_in  = '0;
         step_in  = init_step(qbits_in);
         power_in = 16'(floor_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qbits_ff     <= RST_QUANT_BITS;
         sgain_ff     <= RST_STEP_GAIN;
         pgain_ff     <= RST_PREDICTOR_GAIN;
         cmax_ff      <= RST_CODE_MAX;
         cmin_ff      <= RST_CODE_MIN;
         alpha_ff     <= RST_POWER_ALPHA;
         floor_ff     <= RST_POWER_FLOOR;
         pred_ff      <= '0;
         step_ff      <= init_step(RST_QUANT_BITS);
         power_ff     <= 16'(RST_POWER_FLOOR);
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         qbits_ff     <= qbits_in;
         sgain_ff     <= sgain_in;
         pgain_ff     <= pgain_in;
         cmax_ff      <= cmax_in;
         cmin_ff      <= cmin_in;
         alpha_ff     <= alpha_in;
         floor_ff     <= floor_in;
         pred_ff      <= pred_in;
         step_ff      <= step_in;
         power_ff     <= power_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      code_ff     <= code_in;
      dq_ff       <= dq_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      pw_ff       <= pw_in;
      st_ff       <= st_in;
      prod_ff     <= mul_p;
      rsp_code_ff <= rsp_code_in;
   end

`ifndef SYNTH
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      step_ff != '0)
      else $error("step size reached zero");

   a_power_range: assert property (@(posedge clock) disable iff (reset)
      (power_ff >= 16'(floor_ff)) && (power_ff <= SAT_POS))
      else $error("power estimate outside floor and saturation limits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("sample channel ready right after an item was taken");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   a_div_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !div_status.busy)
      else $error("divider busy while the sample channel is ready");
`endif

endmodule

/* src/asq_div.sv */
// asq_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on asq_pkg.
`timescale 1ns / 1ps

module asq_div import asq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [QUOT_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [QUOT_W-1:0]    quotient,
   output div_status_type       status
);

   localparam int CNT_W = $clog2(QUOT_W + 1);
   localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(QUOT_W);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   trial_sub;
   logic                 fits;

   assign trial     = {rem_ff, quo_ff[QUOT_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign fits      = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_LOAD;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder always stays below the divisor, so it fits its width
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for adaptive_subband_quantizer_core. A directed table,
// then random samples over several register settings, checked against a cycle-free
// predictor. Depends on asq_pkg and the asq_req_if, asq_rsp_if and asq_csr_if interfaces.
`timescale 1ns / 1ps

module testbench;
   import asq_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int PRESSURE_AT     = 500;
   localparam int HOLD_CYCLES     = 400;
   localparam int DIR_ROWS        = 32;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 3'd7;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {MODE_LOW, MODE_HIGH, MODE_RANDOM} phase_mode_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      logic                  typed;
      code_type              code;
   } dir_row_type;

   // typed codes only where the state after a reset or reinit, or a code limit, makes them obvious
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{ROW_SAMPLE, REG_NONE,           16'h0800, 1'b1, 8'sd1},
      '{ROW_SAMPLE, REG_NONE,           16'h7FFF, 1'b1, 8'sd7},
      '{ROW_SAMPLE, REG_NONE,           16'h8000, 1'b1, -8'sd8},
      '{ROW_SAMPLE, REG_NONE,           16'h0000, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'hFFFF, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h0001, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h5555, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'hAAAA, 1'b0, 8'sd0},
      // just under half a step rounds to zero
      '{ROW_WRITE,  REG_POWER_FLOOR,    16'd1,    1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h07FF, 1'b1, 8'sd0},
      // half a step below zero rounds away from zero
      '{ROW_WRITE,  REG_STEP_GAIN,      16'd1024, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'hF800, 1'b1, -8'sd1},
      '{ROW_SAMPLE, REG_NONE,           16'h0000, 1'b0, 8'sd0},
      // widest code, largest gains
      '{ROW_WRITE,  REG_QUANT_BITS,     16'd8,    1'b0, 8'sd0},
      '{ROW_WRITE,  REG_STEP_GAIN,      16'hFFFF, 1'b0, 8'sd0},
      '{ROW_WRITE,  REG_PREDICTOR_GAIN, 16'd63,   1'b0, 8'sd0},
      '{ROW_WRITE,  REG_CODE_MAX,       16'd127,  1'b0, 8'sd0},
      '{ROW_WRITE,  REG_CODE_MIN,       16'h0080, 1'b0, 8'sd0},
      '{ROW_WRITE,  REG_POWER_ALPHA,    16'd1024, 1'b0, 8'sd0},
      '{ROW_WRITE,  REG_POWER_FLOOR,    16'h7FFF, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h7FFF, 1'b1, 8'sd127},
      '{ROW_SAMPLE, REG_NONE,           16'h8000, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h0001, 1'b0, 8'sd0},
      // zero code width, alpha past one, code_min above code_max
      '{ROW_WRITE,  REG_QUANT_BITS,     16'd0,    1'b0, 8'sd0},
      '{ROW_WRITE,  REG_POWER_ALPHA,    16'h07FF, 1'b0, 8'sd0},
      '{ROW_WRITE,  REG_CODE_MAX,       16'd2,    1'b0, 8'sd0},
      '{ROW_WRITE,  REG_CODE_MIN,       16'd5,    1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h7FFF, 1'b1, 8'sd5},
      '{ROW_SAMPLE, REG_NONE,           16'h8000, 1'b0, 8'sd0},
      // code width past eight, code above code_max stays there
      '{ROW_WRITE,  REG_QUANT_BITS,     16'hFFFF, 1'b0, 8'sd0},
      '{ROW_SAMPLE, REG_NONE,           16'h7FFF, 1'b1, 8'sd2},
      '{ROW_WRITE,  REG_NONE,           16'h1234, 1'b0, 8'sd0}
   };

   logic clock;
   logic reset;

   asq_req_if req_if();
   asq_rsp_if rsp_if();
   asq_csr_if csr_if();

   adaptive_subband_quantizer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // register copy and adaptive state of the predictor
   logic [3:0]         cfg_quant_bits;
   logic [15:0]        cfg_step_gain;
   logic [5:0]         cfg_pred_gain;
   logic [6:0]         cfg_code_max;
   logic signed [7:0]  cfg_code_min;
   logic [10:0]        cfg_power_alpha;
   logic [14:0]        cfg_power_floor;
   logic signed [15:0] st_prediction;
   logic [15:0]        st_step;
   logic [15:0]        st_power;

   code_type    expected_codes[$];
   int          fail_count = 0;
   int          accepted_samples = 0;
   int unsigned cycle_count = 0;
   int          send_quiet = 0;
   longint      walk_level = 0;
   bit          req_active = 0;
   bit          csr_active = 0;
   bit          unsettled = 0;
   bit          hold_off = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_quant_bits();
      if (cfg_quant_bits == 0) return 1;
      if (cfg_quant_bits > 8) return 8;
      return int'(cfg_quant_bits);
   endfunction

   function automatic longint sat16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   // add half, then floor divide by 2^n, negative values included
   function automatic longint round_down(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic void reset_state();
      st_prediction = '0;
      st_step       = 16'(32'd1 << (16 - eff_quant_bits()));
      st_power      = 16'(cfg_power_floor);
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      bit known;
      known = 1'b1;
      case (idx)
         REG_QUANT_BITS:     cfg_quant_bits  = data[3:0];
         REG_STEP_GAIN:      cfg_step_gain   = data;
         REG_PREDICTOR_GAIN: cfg_pred_gain   = data[5:0];
         REG_CODE_MAX:       cfg_code_max    = data[6:0];
         REG_CODE_MIN:       cfg_code_min    = data[7:0];
         REG_POWER_ALPHA:    cfg_power_alpha = data[10:0];
         REG_POWER_FLOOR:    cfg_power_floor = data[14:0];
         default:            known = 1'b0;
      endcase
      if (known) reset_state();
   endfunction

   // code for one sample, then power, step and prediction update
   function automatic code_type quantize_and_adapt(sample_type s);
      longint step, alpha, diff, code, dq, mag, pw, st, pr;
      step  = (st_step < 1) ? 1 : longint'(st_step);
      alpha = (cfg_power_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cfg_power_alpha);
      diff  = longint'(s) - longint'(st_prediction);
      if (diff > 0) code = (diff + step / 2) / step;
      else if (diff < 0) code = -((-diff + step / 2) / step);
      else code = 0;

      if (code > longint'(cfg_code_max)) code = longint'(cfg_code_max);
      else if (code < longint'(cfg_code_min)) code = longint'(cfg_code_min);

      dq  = sat16(code * step);
      mag = (dq < 0) ? -dq : dq;
      pw  = round_down(alpha * longint'(st_power) + (longint'(ALPHA_ONE) - alpha) * mag, 10);
      if (pw < longint'(cfg_power_floor)) pw = longint'(cfg_power_floor);
      st  = round_down(longint'(cfg_step_gain) * pw, eff_quant_bits() + 4);
      if (st < 1) st = 1;
      pr  = round_down((longint'(st_prediction) + dq) * longint'(cfg_pred_gain), 5);

      st_prediction = 16'(sat16(pr));
      st_step       = (st > 32767) ? 16'd32767 : 16'(st);
      st_power      = (pw > 32767) ? 16'd32767 : 16'(pw);
      return code_type'(code[7:0]);
   endfunction

   function automatic int pick_value(int lo, int hi, int typ_lo, int typ_hi,
                                     phase_mode_type mode);
      int r;
      if (mode == MODE_LOW) return lo;
      if (mode == MODE_HIGH) return hi;
      r = $urandom_range(0, 9);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_setting(logic [CSR_IDX_W-1:0] idx,
                                                          phase_mode_type mode);
      int qmax;
      int v;
      // raw words now and then, so the unused upper bits get driven too
      if (mode == MODE_RANDOM && $urandom_range(0, 7) == 0) return 16'($urandom());
      qmax = (1 << (eff_quant_bits() - 1)) - 1;
      case (idx)
         REG_QUANT_BITS:     v = pick_value(1, 8, 1, 8, mode);
         REG_STEP_GAIN:      v = pick_value(0, 65535, 256, 4096, mode);
         REG_PREDICTOR_GAIN: v = pick_value(0, 63, 0, 63, mode);
         REG_CODE_MAX:       v = pick_value(0, 127, qmax, qmax, mode);
         REG_CODE_MIN:       v = pick_value(-128, 0, -qmax - 1, -qmax - 1, mode);
         REG_POWER_ALPHA:    v = pick_value(0, 1024, 768, 1024, mode);
         REG_POWER_FLOOR:    v = pick_value(0, 32767, 0, 64, mode);
         default:            v = 0;
      endcase
      return 16'(v);
   endfunction

   // in four of ten draws samples near prediction plus a few steps, so codes spread over the range
   function automatic sample_type next_sample();
      longint step, half, target;
      step = (st_step < 1) ? 1 : longint'(st_step);
      half = longint'(1) <<< (eff_quant_bits() - 1);
      case ($urandom_range(0, 9))
         0, 1: return sample_type'($urandom());
         2: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         3, 4, 5, 6: begin
            target = longint'(st_prediction)
                   + (longint'($urandom_range(0, int'(2 * half))) - half) * step
                   + longint'($urandom_range(0, int'(step))) - step / 2;
            target = sat16(target);
            return sample_type'(target[15:0]);
         end
         default: begin
            walk_level = sat16(walk_level + longint'($urandom_range(0, 4000)) - 2000);
            return sample_type'(walk_level[15:0]);
         end
      endcase
   endfunction

   task automatic drain_codes();
      if (req_active) begin
         req_if.valid <= 1'b0;
         req_active = 1'b0;
      end
      while (expected_codes.size() != 0) @(posedge clock);
      // the state update is done before the code is loaded for output
      repeat (SETTLE_CYCLES) @(posedge clock);
      unsettled = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      if (unsettled) drain_codes();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      csr_active = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      apply_reg_write(idx, data);
   endtask

   task automatic send_sample(input sample_type s, input bit typed, input code_type typed_code);
      int gap;
      int r;
      code_type predicted;
      if (send_quiet > 0) begin
         send_quiet--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 45) gap = 0;
         else if (r < 88) gap = $urandom_range(1, 4);
         else if (r < 97) gap = $urandom_range(10, 60);
         else begin
            gap = 0;
            send_quiet = $urandom_range(20, 80);
         end
      end
      if (csr_active) begin
         csr_if.valid <= 1'b0;
         csr_active = 1'b0;
      end
      if (gap > 0) begin
         if (req_active) req_if.valid <= 1'b0;
         req_active = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      req_active = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predicted = quantize_and_adapt(s);
      expected_codes.push_back(typed ? typed_code : predicted);
      accepted_samples++;
      unsettled = 1'b1;
   endtask

   // code receiver with random back-pressure
   initial begin
      int stall_left;
      int quiet_left;
      int r;
      code_type want;
      stall_left = 0;
      quiet_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: code %0d with no sample pending", $time, rsp_if.code);
               fail_count++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_if.code !== want) begin
                  $display("%0t: code mismatch: expected %0d, actual %0d",
                           $time, want, rsp_if.code);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) stall_left--;
         else if (quiet_left > 0) quiet_left--;
         else begin
            r = $urandom_range(0, 99);
            if (r >= 98) quiet_left = $urandom_range(30, 150);
            else if (r >= 95) stall_left = $urandom_range(15, 60);
            else if (r >= 70) stall_left = $urandom_range(1, 4);
         end
         rsp_if.ready <= !hold_off && stall_left == 0;
      end
   end

   // one long hold-off on the code side while samples keep coming
   initial begin
      wait (accepted_samples >= PRESSURE_AT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      phase_mode_type mode;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      csr_if.valid  = 1'b0;
      csr_if.index  = '0;
      csr_if.wdata  = '0;

      cfg_quant_bits  = RST_QUANT_BITS;
      cfg_step_gain   = RST_STEP_GAIN;
      cfg_pred_gain   = RST_PREDICTOR_GAIN;
      cfg_code_max    = RST_CODE_MAX;
      cfg_code_min    = RST_CODE_MIN;
      cfg_power_alpha = RST_POWER_ALPHA;
      cfg_power_floor = RST_POWER_FLOOR;
      reset_state();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_WRITE)
            write_reg(DIRECTED[i].index, DIRECTED[i].value);
         else
            send_sample(sample_type'(DIRECTED[i].value), DIRECTED[i].typed, DIRECTED[i].code);
      end

      // first all low ends, then all high ends, then mixed settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         mode = (p == 0) ? MODE_LOW : (p == 1) ? MODE_HIGH : MODE_RANDOM;
         for (int ri = 0; ri < NUM_REGS; ri++)
            write_reg(ri[CSR_IDX_W-1:0], reg_setting(ri[CSR_IDX_W-1:0], mode));
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(next_sample(), 1'b0, '0);
      end

      drain_codes();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
src/asq_pkg.sv
src/asq_req_if.sv
src/asq_rsp_if.sv
src/asq_csr_if.sv
src/asq_div.sv
src/adaptive_subband_quantizer_core.sv
sim/testbench.sv
